// File: design/rss_pkg.sv
// Package for the record sorter: record type, ordering function, defaults.
// Used by record_sort_score_desc_name_asc_top and by the testbench.
// No dependencies.
package rss_pkg;

   // Default store capacity
   localparam int MAX_RECORDS_DEFAULT = 32;

   // One stored record: signed score, 20-byte name in three big-endian fields
   typedef struct packed {
      logic signed [31:0] score;
      logic [63:0]        name_head;
      logic [63:0]        name_middle;
      logic [31:0]        name_tail;
   } rec_type;

   // True when record a goes out ahead of record b: higher score first,
   // lower 160-bit name first on equal scores
   function automatic logic ranks_before(input rec_type a, input rec_type b);
      logic [159:0] name_a;
      logic [159:0] name_b;
      name_a = {a.name_head, a.name_middle, a.name_tail};
      name_b = {b.name_head, b.name_middle, b.name_tail};
      if (a.score != b.score) begin
         return a.score > b.score;
      end
      return name_a < name_b;
   endfunction

endpackage

// File: design/record_sort_score_desc_name_asc_top.sv
// Record sorter top level: record store, selection sequencer, result strobe.
// Depends on rss_pkg (record type, ordering function, default capacity).
//
//   channel   ports                                   handshake
//   request   req_score, req_name_*, req_final_record start high, busy low
//   result    rsp_sorted_*, rsp_run_end,
//             rsp_records_dropped                     rsp_valid, one cycle
//
// Each accepted request loads one record while the store has room. After
// the final record, each rank steps through fetch, first read, a scan of
// each remaining record in turn on the single memory read port and the one
// comparator, then the result. busy is high from the final request until
// the result flagged rsp_run_end. Reset is synchronous and clears the
// sequencer, record count and drop flag; the store itself is not cleared.
// Results cannot be stalled.
module record_sort_score_desc_name_asc_top #(
   parameter int MAX_RECORDS = rss_pkg::MAX_RECORDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_score,
   input  logic [63:0]         req_name_head,
   input  logic [63:0]         req_name_middle,
   input  logic [31:0]         req_name_tail,
   input  logic                req_final_record,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_sorted_score,
   output logic [63:0]         rsp_sorted_name_head,
   output logic [63:0]         rsp_sorted_name_middle,
   output logic [31:0]         rsp_sorted_name_tail,
   output logic                rsp_run_end,
   output logic                rsp_records_dropped
);

   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_RECORDS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_FIRST = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] rank_ff, rank_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   rss_pkg::rec_type best_ff, best_in;
   rss_pkg::rec_type first_ff, first_in;
   rss_pkg::rec_type mem_rd_ff;

   rss_pkg::rec_type mem [MAX_RECORDS];

   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_addr;
   rss_pkg::rec_type mem_wr_data;
   logic [IDX_W-1:0] rd_ptr;
   logic             accept;
   logic             better;
   logic [CNT_W-1:0] rank_next;
   logic [CNT_W-1:0] scan_next;
   logic             last_rank;

   assign accept    = start && (state_ff == ST_IDLE);
   assign rank_next = CNT_W'(rank_ff + 1'b1);
   assign scan_next = CNT_W'(scan_ff + 1'b1);
   assign last_rank = (rank_next == count_ff);

   // Shared comparator: memory read word against the current best
   assign better = rss_pkg::ranks_before(mem_rd_ff, best_ff);

   // Read address for the next cycle's compare
   always_comb begin
      unique case (state_ff)
         ST_FETCH: rd_ptr = rank_ff[IDX_W-1:0];
         ST_FIRST: rd_ptr = rank_next[IDX_W-1:0];
         ST_SCAN:  rd_ptr = scan_next[IDX_W-1:0];
         default:  rd_ptr = rank_ff[IDX_W-1:0];
      endcase
   end

   // Write port: load a request, or swap the old rank entry into the winner slot
   always_comb begin
      mem_we      = 1'b0;
      mem_wr_addr = best_idx_ff;
      mem_wr_data = first_ff;
      if (accept && (count_ff < CAP)) begin
         mem_we      = 1'b1;
         mem_wr_addr = count_ff[IDX_W-1:0];
         mem_wr_data = '{score: req_score, name_head: req_name_head,
                         name_middle: req_name_middle, name_tail: req_name_tail};
      end else if (state_ff == ST_EMIT) begin
         mem_we = 1'b1;
      end
   end

   // Record store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      mem_rd_ff <= mem[rd_ptr];
   end

   // Sequencer: load, then select the best remaining record for each rank
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      rank_in     = rank_ff;
      scan_in     = scan_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      first_in    = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CAP) begin
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_final_record) begin
                  rank_in  = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            best_in     = mem_rd_ff;
            first_in    = mem_rd_ff;
            best_idx_in = rank_ff[IDX_W-1:0];
            scan_in     = rank_next;
            state_in    = last_rank ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN: begin
            if (better) begin
               best_in     = mem_rd_ff;
               best_idx_in = scan_ff[IDX_W-1:0];
            end
            scan_in = scan_next;
            if (scan_next == count_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rank_in = rank_next;
            if (last_rank) begin
               count_in    = '0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rank_ff     <= rank_in;
      scan_ff     <= scan_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      first_ff    <= first_in;
   end

   // Result strobe
   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = (state_ff == ST_EMIT);
   assign rsp_sorted_score       = best_ff.score;
   assign rsp_sorted_name_head   = best_ff.name_head;
   assign rsp_sorted_name_middle = best_ff.name_middle;
   assign rsp_sorted_name_tail   = best_ff.name_tail;
   assign rsp_run_end            = last_rank;
   assign rsp_records_dropped    = overflow_ff;

endmodule

// File: design/rss_port_checker.sv
// Port checker for the record sorter, bound to its top level.
// Depends only on the top level's handshake ports.
module rss_port_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_final_record,
   input logic rsp_valid,
   input logic rsp_run_end
);

   // Results appear only while a sort is running
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a sort");

   // A final request starts the sort
   a_final_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_final_record) |=> busy)
      else $error("final request did not start the sort");

   // A plain request leaves the block ready
   a_load_stays_ready: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_final_record) |=> !busy)
      else $error("plain request made the block busy");

   // The last result ends the sort
   a_run_end_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_end) |=> (!busy && !rsp_valid))
      else $error("sort did not end after the last result");

   // More results follow one that is not the last
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_run_end) |=> (busy && !rsp_valid))
      else $error("sort ended early");

endmodule

bind record_sort_score_desc_name_asc_top rss_port_checker u_rss_port_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_final_record (req_final_record),
   .rsp_valid        (rsp_valid),
   .rsp_run_end      (rsp_run_end)
);

// File: test/tb_sort_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the record sorter testbench: ranked-record type and a class
// that predicts the sorted output of each set and checks the block against it.
// Depends on rss_pkg (rec_type).
package tb_sort_pkg;
   import rss_pkg::*;

   // One emitted rank, laid out in the order of the result ports
   typedef struct packed {
      rec_type rec;
      logic    run_end;
      logic    dropped;
   } ranked_record_type;

   class sort_scoreboard;
      int                capacity;
      rec_type           open_set[$];
      bit                overflow_seen;
      ranked_record_type expected_ranks[$];
      int                errors;

      function new(int capacity_value);
         capacity = capacity_value;
         overflow_seen = 1'b0;
         errors = 0;
      endfunction

      // Higher score first; on a tie the smaller 160-bit name first
      function bit outranks(rec_type a, rec_type b);
         if ($signed(a.score) != $signed(b.score)) begin
            return $signed(a.score) > $signed(b.score);
         end
         return {a.name_head, a.name_middle, a.name_tail} <
                {b.name_head, b.name_middle, b.name_tail};
      endfunction

      // Note an accepted request; a final record releases the sorted set
      function void note_request(rec_type rec, bit last_flag);
         rec_type           ordered[$];
         ranked_record_type row;
         int                slot;
         // store, or drop once the set is full
         if (open_set.size() < capacity) begin
            open_set.push_back(rec);
         end else begin
            overflow_seen = 1'b1;
         end
         if (!last_flag) begin
            return;
         end
         // insert each record ahead of the first one it outranks
         foreach (open_set[i]) begin
            slot = 0;
            while (slot < ordered.size() && !outranks(open_set[i], ordered[slot])) begin
               slot++;
            end
            ordered.insert(slot, open_set[i]);
         end
         foreach (ordered[i]) begin
            row.rec = ordered[i];
            row.run_end = (i == ordered.size() - 1);
            row.dropped = overflow_seen;
            expected_ranks.push_back(row);
         end
         open_set.delete();
         overflow_seen = 1'b0;
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      // Check one emitted rank against the oldest expectation
      function void check_result(ranked_record_type got);
         ranked_record_type want;
         if (expected_ranks.size() == 0) begin
            $display("%0t: result with nothing expected, actual score %h name %h%h%h",
                     $time, got.rec.score, got.rec.name_head, got.rec.name_middle,
                     got.rec.name_tail);
            errors++;
            return;
         end
         want = expected_ranks.pop_front();
         compare_field("sorted_score", want.rec.score, got.rec.score);
         compare_field("sorted_name_head", want.rec.name_head, got.rec.name_head);
         compare_field("sorted_name_middle", want.rec.name_middle, got.rec.name_middle);
         compare_field("sorted_name_tail", want.rec.name_tail, got.rec.name_tail);
         compare_field("run_end", want.run_end, got.run_end);
         compare_field("records_dropped", want.dropped, got.dropped);
      endfunction

      function int pending();
         return expected_ranks.size();
      endfunction
   endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for record_sort_score_desc_name_asc_top: drives record
// sets with random idling and checks every sorted rank on the fly.
// Depends on rss_pkg, tb_sort_pkg (sort_scoreboard) and the design top level.
module tb_top;
   import rss_pkg::*;
   import tb_sort_pkg::*;

   localparam int CAPACITY = rss_pkg::MAX_RECORDS_DEFAULT;
   localparam int TARGET_RECORDS = 380;
   localparam int QUIET_AFTER = 320;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_score = '0;
   logic [63:0]        req_name_head = '0;
   logic [63:0]        req_name_middle = '0;
   logic [31:0]        req_name_tail = '0;
   logic               req_final_record = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_sorted_score;
   logic [63:0]        rsp_sorted_name_head;
   logic [63:0]        rsp_sorted_name_middle;
   logic [31:0]        rsp_sorted_name_tail;
   logic               rsp_run_end;
   logic               rsp_records_dropped;

   sort_scoreboard board;

   record_sort_score_desc_name_asc_top #(
      .MAX_RECORDS(CAPACITY)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_score              (req_score),
      .req_name_head          (req_name_head),
      .req_name_middle        (req_name_middle),
      .req_name_tail          (req_name_tail),
      .req_final_record       (req_final_record),
      .rsp_valid              (rsp_valid),
      .rsp_sorted_score       (rsp_sorted_score),
      .rsp_sorted_name_head   (rsp_sorted_name_head),
      .rsp_sorted_name_middle (rsp_sorted_name_middle),
      .rsp_sorted_name_tail   (rsp_sorted_name_tail),
      .rsp_run_end            (rsp_run_end),
      .rsp_records_dropped    (rsp_records_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Check every strobed rank at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_result(ranked_record_type'({rsp_sorted_score, rsp_sorted_name_head,
                                                 rsp_sorted_name_middle,
                                                 rsp_sorted_name_tail,
                                                 rsp_run_end, rsp_records_dropped}));
      end
   end

   // Pack a string into the 20-byte big-endian name, zero padded
   function automatic logic [159:0] name_from(string s);
      logic [159:0] nm;
      nm = '0;
      for (int i = 0; i < s.len() && i < 20; i++) begin
         nm[159 - 8*i -: 8] = s[i];
      end
      return nm;
   endfunction

   // Random name of len bytes drawn from [lo, hi], zero padded
   function automatic logic [159:0] make_name(int len, int lo, int hi);
      logic [159:0] nm;
      nm = '0;
      for (int i = 0; i < len; i++) begin
         nm[159 - 8*i -: 8] = 8'($urandom_range(lo, hi));
      end
      return nm;
   endfunction

   function automatic rec_type record_of(logic [31:0] score, logic [159:0] nm);
      rec_type rec;
      rec.score = score;
      {rec.name_head, rec.name_middle, rec.name_tail} = nm;
      return rec;
   endfunction

   // Mix of full-range values, tie-prone scores and prefix-related names
   function automatic rec_type random_record();
      logic [31:0]  score;
      logic [159:0] nm;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: score = $urandom;
         4, 5, 6:    score = $urandom_range(0, 4) - 2;
         7:          score = 32'h8000_0000;
         8:          score = 32'h7fff_ffff;
         default:    score = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
         4, 5, 6:    nm = make_name($urandom_range(0, 20), 65, 67);
         7, 8:       nm = make_name($urandom_range(0, 4), 65, 65);
         default:    nm = $urandom_range(0, 1) ? {160{1'b1}} : {160{1'b0}};
      endcase
      return record_of(score, nm);
   endfunction

   // Hold start low for the given gap, then present the request until accepted
   task automatic send_record(input rec_type rec, input bit last_flag, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_score <= rec.score;
      req_name_head <= rec.name_head;
      req_name_middle <= rec.name_middle;
      req_name_tail <= rec.name_tail;
      req_final_record <= last_flag;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(rec, last_flag);
   endtask

   // Drop start and hold off until every expected rank has come out
   task automatic wait_for_drain();
      start <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int records_sent;
      int set_index;
      int set_size;
      int gap;
      bit quiet;
      logic [159:0] shared;
      logic [159:0] near_shared;
      logic [159:0] tail_aaab;
      logic [159:0] tail_aaaa;
      logic [159:0] tail_zzzz;

      board = new(CAPACITY);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed set: score extremes, ties broken in each name field,
      // a name that prefixes another, identical records
      shared = name_from("SAMEHEADSAMEMIDL");
      near_shared = name_from("SAMEHEADSAMEMIDK");
      tail_aaab = name_from("AAAB");
      tail_aaaa = name_from("AAAA");
      tail_zzzz = name_from("ZZZZ");
      send_record(record_of(32'h7fff_ffff, name_from("ALPHA")), 1'b0, 0);
      send_record(record_of(32'h8000_0000, {160{1'b0}}), 1'b0, 2);
      send_record(record_of(32'h0, {160{1'b1}}), 1'b0, 0);
      send_record(record_of(32'hffff_ffff, name_from("BETA")), 1'b0, 0);
      send_record(record_of(32'h1, name_from("B")), 1'b0, 5);
      send_record(record_of(32'h1, name_from("A")), 1'b0, 0);
      send_record(record_of(32'h1, name_from("AB")), 1'b0, 0);
      send_record(record_of(32'h5, {shared[159:32], tail_aaab[159:128]}), 1'b0, 0);
      send_record(record_of(32'h5, {shared[159:32], tail_aaaa[159:128]}), 1'b0, 1);
      send_record(record_of(32'h5, {near_shared[159:32], tail_zzzz[159:128]}), 1'b0, 0);
      send_record(record_of(32'h7, name_from("TWIN")), 1'b0, 0);
      send_record(record_of(32'h7, name_from("TWIN")), 1'b1, 0);
      // Set of one, all bits high
      send_record(record_of(32'hffff_ffff, {160{1'b1}}), 1'b1, 0);
      // Two records that differ only in the last name bit
      send_record(record_of(32'h8000_0000, 160'h1), 1'b0, 0);
      send_record(record_of(32'h8000_0000, 160'h0), 1'b1, 3);
      wait_for_drain();

      // Random sets; the first two overflow the store, both with the final
      // record itself dropped
      records_sent = 15;
      set_index = 0;
      while (records_sent < TARGET_RECORDS) begin
         if (set_index == 0) begin
            set_size = CAPACITY + 1;
         end else if (set_index == 1) begin
            set_size = CAPACITY + 5;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: set_size = $urandom_range(1, 6);
               12, 13, 14, 15, 16:                   set_size = $urandom_range(7, 20);
               17, 18:                               set_size = CAPACITY;
               default: set_size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            endcase
         end
         quiet = (records_sent > QUIET_AFTER) || ($urandom_range(0, 3) == 0);
         for (int k = 0; k < set_size; k++) begin
            gap = 0;
            if (!quiet && $urandom_range(0, 2) == 0) begin
               gap = $urandom_range(1, 15);
            end
            send_record(random_record(), k == set_size - 1, gap);
         end
         records_sent += (set_size < CAPACITY) ? set_size : CAPACITY;
         set_index++;
         if (records_sent <= QUIET_AFTER && $urandom_range(0, 9) == 0) begin
            wait_for_drain();
         end
      end

      // Let the last set drain, then watch for stray strobes
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
